/* design/pcbb_pkg.sv */
// Shared types and constants for the point cloud bounding box unit.
// No dependencies.
`timescale 1ns / 1ps

package pcbb_pkg;

    // Operand select codes for the shared squaring multiplier
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // Controller to datapath command word
    typedef struct packed {
        logic       pt_take;   // fold the incoming point into the extremes
        logic       first;     // point opens a set: load all extremes
        logic       wid_load;  // latch widths, clear accumulator and root
        logic       mul_en;    // square the selected width
        logic [1:0] mul_sel;   // width picked for squaring
        logic       acc_en;    // add last product into the sum of squares
        logic       root_step; // one digit of the square root
        logic       out_load;  // move box and diagonal into the output register
    } t_dp_cmd;

endpackage

/* design/pcbb_if.sv */
// Request channel interfaces: input points and output boxes.
// Depends on nothing; width follows COORD_BITS.
`timescale 1ns / 1ps

interface pcbb_pt_if #(parameter int COORD_BITS = 24);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] point_z;
    logic                         last_point;

    modport source (output valid, point_x, point_y, point_z, last_point, input ready);
    modport sink   (input valid, point_x, point_y, point_z, last_point, output ready);
endinterface

interface pcbb_box_if #(parameter int COORD_BITS = 24);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] min_x;
    logic signed [COORD_BITS-1:0] min_y;
    logic signed [COORD_BITS-1:0] min_z;
    logic signed [COORD_BITS-1:0] max_x;
    logic signed [COORD_BITS-1:0] max_y;
    logic signed [COORD_BITS-1:0] max_z;
    logic        [COORD_BITS-1:0] width_x;
    logic        [COORD_BITS-1:0] width_y;
    logic        [COORD_BITS-1:0] width_z;
    logic        [COORD_BITS-1:0] width_largest;
    logic        [COORD_BITS-1:0] width_xz_largest;
    logic        [COORD_BITS:0]   diagonal;

    modport source (
        output valid, min_x, min_y, min_z, max_x, max_y, max_z,
               width_x, width_y, width_z, width_largest, width_xz_largest, diagonal,
        input  ready
    );
    modport sink (
        input  valid, min_x, min_y, min_z, max_x, max_y, max_z,
               width_x, width_y, width_z, width_largest, width_xz_largest, diagonal,
        output ready
    );
endinterface

/* design/pcbb_ctrl.sv */
// Sequencing FSM: accepts points, steps squaring and root, owns output valid.
// Depends on pcbb_pkg.
`timescale 1ns / 1ps

module pcbb_ctrl #(
    parameter int COORD_BITS = 24
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_last,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output pcbb_pkg::t_dp_cmd o_cmd
);
    import pcbb_pkg::*;

    localparam int CW = $clog2(COORD_BITS + 2);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_WID  = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_ROOT = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_set_empty, n_set_empty;
    logic          r_out_valid, n_out_valid;
    logic          w_take;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_take      = o_in_ready & i_in_valid;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_set_empty = r_set_empty;
        n_out_valid = r_out_valid & ~i_out_ready;
        o_cmd       = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_take) begin
                    o_cmd.pt_take = 1'b1;
                    o_cmd.first   = r_set_empty;
                    n_set_empty   = i_in_last;
                    if (i_in_last) begin
                        n_state = ST_WID;
                    end
                end
            end
            ST_WID: begin
                o_cmd.wid_load = 1'b1;
                n_cnt          = '0;
                n_state        = ST_MUL;
            end
            ST_MUL: begin
                // three squares through one multiplier, each product accumulated after it is registered
                o_cmd.mul_en  = (r_cnt < CW'(3));
                o_cmd.mul_sel = r_cnt[1:0];
                o_cmd.acc_en  = (r_cnt != '0);
                n_cnt         = r_cnt + 1'b1;
                if (r_cnt == CW'(3)) begin
                    n_cnt   = '0;
                    n_state = ST_ROOT;
                end
            end
            ST_ROOT: begin
                o_cmd.root_step = 1'b1;
                n_cnt           = r_cnt + 1'b1;
                if (r_cnt == CW'(COORD_BITS)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_set_empty <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_set_empty <= n_set_empty;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

/* design/pcbb_dp.sv */
// Datapath: running extremes, widths, shared squarer, digit-serial root, result register.
// Depends on pcbb_pkg.
`timescale 1ns / 1ps

module pcbb_dp #(
    parameter int COORD_BITS = 24
) (
    input  logic                         i_clk,
    input  pcbb_pkg::t_dp_cmd            i_cmd,
    input  logic signed [COORD_BITS-1:0] i_point_x,
    input  logic signed [COORD_BITS-1:0] i_point_y,
    input  logic signed [COORD_BITS-1:0] i_point_z,
    output logic signed [COORD_BITS-1:0] o_min_x,
    output logic signed [COORD_BITS-1:0] o_min_y,
    output logic signed [COORD_BITS-1:0] o_min_z,
    output logic signed [COORD_BITS-1:0] o_max_x,
    output logic signed [COORD_BITS-1:0] o_max_y,
    output logic signed [COORD_BITS-1:0] o_max_z,
    output logic        [COORD_BITS-1:0] o_width_x,
    output logic        [COORD_BITS-1:0] o_width_y,
    output logic        [COORD_BITS-1:0] o_width_z,
    output logic        [COORD_BITS-1:0] o_width_largest,
    output logic        [COORD_BITS-1:0] o_width_xz_largest,
    output logic        [COORD_BITS:0]   o_diagonal
);
    import pcbb_pkg::*;

    localparam int W  = COORD_BITS;
    localparam int SW = 2 * W + 2;  // sum of three squares
    localparam int RW = W + 4;      // root remainder

    logic signed [W-1:0] r_low_x, r_low_y, r_low_z;
    logic signed [W-1:0] r_high_x, r_high_y, r_high_z;
    logic [W-1:0]        r_wx, r_wy, r_wz;
    logic [W-1:0]        w_op;
    logic [2*W-1:0]      w_sq, r_prod;
    logic [SW-1:0]       r_acc;
    logic [RW-1:0]       r_rem;
    logic [W:0]          r_root;
    logic [RW+1:0]       w_shift, w_trial, w_diff;
    logic                w_fits;
    logic [W-1:0]        w_xz_max, w_xy_max;

    // running extremes
    always_ff @(posedge i_clk) begin
        if (i_cmd.pt_take) begin
            if (i_cmd.first) begin
                r_low_x  <= i_point_x;
                r_low_y  <= i_point_y;
                r_low_z  <= i_point_z;
                r_high_x <= i_point_x;
                r_high_y <= i_point_y;
                r_high_z <= i_point_z;
            end else begin
                if (i_point_x < r_low_x)  r_low_x  <= i_point_x;
                if (i_point_y < r_low_y)  r_low_y  <= i_point_y;
                if (i_point_z < r_low_z)  r_low_z  <= i_point_z;
                if (i_point_x > r_high_x) r_high_x <= i_point_x;
                if (i_point_y > r_high_y) r_high_y <= i_point_y;
                if (i_point_z > r_high_z) r_high_z <= i_point_z;
            end
        end
    end

    always_comb begin
        case (i_cmd.mul_sel)
            AXIS_X:  w_op = r_wx;
            AXIS_Y:  w_op = r_wy;
            default: w_op = r_wz;
        endcase
    end

    assign w_sq = {{W{1'b0}}, w_op} * {{W{1'b0}}, w_op};

    // restoring square root, two radicand bits per step
    assign w_shift = {r_rem, r_acc[SW-1 -: 2]};
    assign w_trial = {3'b000, r_root, 2'b01};
    assign w_fits  = (w_shift >= w_trial);
    assign w_diff  = w_shift - w_trial;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wid_load) begin
            r_wx   <= W'(r_high_x - r_low_x);
            r_wy   <= W'(r_high_y - r_low_y);
            r_wz   <= W'(r_high_z - r_low_z);
            r_acc  <= '0;
            r_rem  <= '0;
            r_root <= '0;
        end
        if (i_cmd.mul_en) begin
            r_prod <= w_sq;
        end
        if (i_cmd.acc_en) begin
            r_acc <= r_acc + {2'b00, r_prod};
        end
        if (i_cmd.root_step) begin
            r_acc  <= {r_acc[SW-3:0], 2'b00};
            r_rem  <= w_fits ? w_diff[RW-1:0] : w_shift[RW-1:0];
            r_root <= {r_root[W-1:0], w_fits};
        end
    end

    assign w_xz_max = (r_wx > r_wz) ? r_wx : r_wz;
    assign w_xy_max = (r_wx > r_wy) ? r_wx : r_wy;

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_min_x            <= r_low_x;
            o_min_y            <= r_low_y;
            o_min_z            <= r_low_z;
            o_max_x            <= r_high_x;
            o_max_y            <= r_high_y;
            o_max_z            <= r_high_z;
            o_width_x          <= r_wx;
            o_width_y          <= r_wy;
            o_width_z          <= r_wz;
            o_width_xz_largest <= w_xz_max;
            o_width_largest    <= (r_wz > w_xy_max) ? r_wz : w_xy_max;
            o_diagonal         <= r_root;
        end
    end

endmodule

/* design/point_cloud_bounding_box_unit.sv */
// Throughput: one point without the last flag per cycle while idle; ready stays high.
// A last point holds ready low after its accept edge while the unit latches the widths,
// runs the shared squarer, forms the COORD_BITS+1 root digits (one per cycle) and loads
// the result register. The result becomes valid as that register loads.
// The load waits, and ready stays low, while an earlier box request is not yet taken.
// Reset (i_rst_n low, synchronous): no result pending, next point opens a set.
// Depends on pcbb_pkg, pcbb_if, pcbb_ctrl, pcbb_dp.
`timescale 1ns / 1ps

module point_cloud_bounding_box_unit #(
    parameter int COORD_BITS = 24
) (
    input  logic i_clk,
    input  logic i_rst_n,
    pcbb_pt_if.sink    i_pt,
    pcbb_box_if.source o_box
);
    import pcbb_pkg::*;

    t_dp_cmd w_cmd;

    // FSM: point acceptance, step counting, output valid/ready
    pcbb_ctrl #(
        .COORD_BITS (COORD_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_pt.valid),
        .i_in_last   (i_pt.last_point),
        .o_in_ready  (i_pt.ready),
        .o_out_valid (o_box.valid),
        .i_out_ready (o_box.ready),
        .o_cmd       (w_cmd)
    );

    // Arithmetic and the result register; result holds while a request waits
    pcbb_dp #(
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_cmd              (w_cmd),
        .i_point_x          (i_pt.point_x),
        .i_point_y          (i_pt.point_y),
        .i_point_z          (i_pt.point_z),
        .o_min_x            (o_box.min_x),
        .o_min_y            (o_box.min_y),
        .o_min_z            (o_box.min_z),
        .o_max_x            (o_box.max_x),
        .o_max_y            (o_box.max_y),
        .o_max_z            (o_box.max_z),
        .o_width_x          (o_box.width_x),
        .o_width_y          (o_box.width_y),
        .o_width_z          (o_box.width_z),
        .o_width_largest    (o_box.width_largest),
        .o_width_xz_largest (o_box.width_xz_largest),
        .o_diagonal         (o_box.diagonal)
    );

endmodule

/* design/pcbb_checker.sv */
// Port-level checks for the bounding box unit, bound onto the top level.
// Depends on pcbb_if (through the bind connections).
`timescale 1ns / 1ps

module pcbb_checker #(
    parameter int COORD_BITS = 24
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic                         i_in_last,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic signed [COORD_BITS-1:0] i_min_x,
    input logic signed [COORD_BITS-1:0] i_max_x,
    input logic signed [COORD_BITS-1:0] i_min_z,
    input logic signed [COORD_BITS-1:0] i_max_z,
    input logic        [COORD_BITS-1:0] i_width_x,
    input logic        [COORD_BITS-1:0] i_width_y,
    input logic        [COORD_BITS-1:0] i_width_z,
    input logic        [COORD_BITS-1:0] i_width_largest
);

    // result request holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result request dropped before it was taken");

    // a last point, once taken, stops intake
    a_busy_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_last |=> !i_in_ready)
        else $error("point taken while a box is being finished");

    a_corner_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_min_x <= i_max_x) && (i_min_z <= i_max_z))
        else $error("box corners out of order");

    a_width_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_width_x == COORD_BITS'(i_max_x - i_min_x))
        else $error("x width does not match corners");

    a_largest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_width_largest >= i_width_x) && (i_width_largest >= i_width_y)
                        && (i_width_largest >= i_width_z)
                        && ((i_width_largest == i_width_x) || (i_width_largest == i_width_y)
                            || (i_width_largest == i_width_z)))
        else $error("largest width is not the largest axis width");

endmodule

bind point_cloud_bounding_box_unit pcbb_checker #(
    .COORD_BITS (COORD_BITS)
) u_pcbb_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_pt.valid),
    .i_in_ready      (i_pt.ready),
    .i_in_last       (i_pt.last_point),
    .i_out_valid     (o_box.valid),
    .i_out_ready     (o_box.ready),
    .i_min_x         (o_box.min_x),
    .i_max_x         (o_box.max_x),
    .i_min_z         (o_box.min_z),
    .i_max_z         (o_box.max_z),
    .i_width_x       (o_box.width_x),
    .i_width_y       (o_box.width_y),
    .i_width_z       (o_box.width_z),
    .i_width_largest (o_box.width_largest)
);
